@@ rtl/multichannel_adc_level_period_tracker_defines.svh @@
// Assertion macros used by the tracker RTL.
`ifndef MULTICHANNEL_ADC_LEVEL_PERIOD_TRACKER_DEFINES_SVH
`define MULTICHANNEL_ADC_LEVEL_PERIOD_TRACKER_DEFINES_SVH

`ifndef SYNTHESIS
`define MALPT_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`define MALPT_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define MALPT_ASSERT_IMP(lbl, ante, cons, msg)
`define MALPT_ASSERT_NXT(lbl, ante, cons, msg)
`endif

`endif

@@ rtl/malpt_pkg.sv @@
`timescale 1ns / 1ps
package malpt_pkg;

  localparam int NUM_CHANNELS = 8;
  localparam int SAMPLE_BITS  = 12;

  localparam int CH_W    = $clog2(NUM_CHANNELS);
  localparam int IN_CH_W = 4;
  localparam int OUT_CH_W = 3;
  localparam int RAW_W   = 12;
  localparam int AVG_W   = 12;
  localparam int SUM_W   = 32;
  localparam int CNT_W   = 16;
  localparam int TICK_W  = 32;
  localparam int TP_W    = 16;
  localparam int TH_W    = 16;
  localparam int EN_W    = 8;
  localparam int CFG_W   = 16;
  localparam int CFG_IDX_W = 2;

  localparam int CMP_W = (SAMPLE_BITS + 3 > TH_W + 2) ? SAMPLE_BITS + 3 : TH_W + 2;

  localparam int MUL_STEPS = TP_W;
  localparam int DIV_STEPS = SUM_W;
  localparam int MAX_STEPS_A = (MUL_STEPS > DIV_STEPS) ? MUL_STEPS : DIV_STEPS;
  localparam int MAX_STEPS = (MAX_STEPS_A > NUM_CHANNELS) ? MAX_STEPS_A : NUM_CHANNELS;
  localparam int STEP_W = $clog2(MAX_STEPS);

  localparam logic [EN_W-1:0] EN_RST      = 8'd255;
  localparam logic [TH_W-1:0] TH_HI_RST   = 16'd2500;
  localparam logic [TH_W-1:0] TH_LO_RST   = 16'd1000;
  localparam logic [TP_W-1:0] TP_RST      = 16'd100;

  typedef enum logic [1:0] {
    MODE_TICK   = 2'd0,
    MODE_SAMPLE = 2'd1,
    MODE_READ   = 2'd2,
    MODE_SELECT = 2'd3
  } mode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CH_EN   = 2'd0,
    CFG_TH_HI   = 2'd1,
    CFG_TH_LO   = 2'd2,
    CFG_TICK_US = 2'd3
  } cfg_idx_t;

endpackage

@@ rtl/multichannel_adc_level_period_tracker.sv @@
`timescale 1ns / 1ps
// Channel   Handshake            Payload
// in_       in_valid/in_ready    in_mode, in_channel, in_sample_value
// out_      out_valid/out_ready  out_channel, out_average, out_period_us,
//                                out_rising_edge, out_level, out_accepted
// cfg_      cfg_we               cfg_index, cfg_data
//
// One request at a time; a tick, a sample without a rising edge or an idle read goes
// from the execute state straight to the done state, where its result is registered;
// a rising edge first runs the bit-serial period multiplier, a read of a nonempty
// channel the bit-serial divider, a select the channel scan.
// A new request is taken the cycle after its result is registered, while it waits.
// Synchronous active-low reset clears the channel stores, tick counter, levels and output
// valid, and loads the config defaults. A stalled output holds the finished request until taken.
`include "multichannel_adc_level_period_tracker_defines.svh"

module multichannel_adc_level_period_tracker
  import malpt_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [1:0]           in_mode,
  input  logic [IN_CH_W-1:0]   in_channel,
  input  logic [RAW_W-1:0]     in_sample_value,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [OUT_CH_W-1:0]  out_channel,
  output logic [AVG_W-1:0]     out_average,
  output logic [TICK_W-1:0]    out_period_us,
  output logic                 out_rising_edge,
  output logic                 out_level,
  output logic                 out_accepted,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_EXEC = 6'b000010,
    S_MUL  = 6'b000100,
    S_DIV  = 6'b001000,
    S_SEL  = 6'b010000,
    S_DONE = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  logic [EN_W-1:0]        en_r;
  logic [TH_W-1:0]        th_hi_r;
  logic [TH_W-1:0]        th_lo_r;
  logic [TP_W-1:0]        tp_r;

  logic [SUM_W-1:0]       sum_r  [NUM_CHANNELS];
  logic [CNT_W-1:0]       cnt_r  [NUM_CHANNELS];
  logic [TICK_W-1:0]      edge_r [NUM_CHANNELS];
  logic [NUM_CHANNELS-1:0] lvl_r;
  logic [TICK_W-1:0]      tick_r;
  logic [CH_W-1:0]        cur_r;

  mode_t                  mode_r;
  logic [IN_CH_W-1:0]     ch_r;
  logic [SAMPLE_BITS-1:0] raw_r;
  logic [CH_W-1:0]        idx_r;
  logic [STEP_W-1:0]      step_r;

  logic [TICK_W-1:0]      mcand_r;
  logic [TP_W-1:0]        mplier_r;
  logic [TICK_W-1:0]      prod_r;
  logic [SUM_W-1:0]       quo_r;
  logic [CNT_W-1:0]       rem_r;
  logic [CNT_W-1:0]       div_r;

  logic [OUT_CH_W-1:0]    res_ch_r;
  logic                   res_edge_r;
  logic                   res_lvl_r;
  logic                   res_acc_r;
  logic                   res_avg_en_r;
  logic                   out_valid_r;

  logic [CMP_W-1:0]       raw5;
  logic [CMP_W-1:0]       hi4;
  logic [CMP_W-1:0]       lo4;
  logic                   go_hi;
  logic                   go_lo;
  logic                   ch_ok;
  logic [SUM_W-1:0]       sum_sel;
  logic [CNT_W-1:0]       cnt_sel;
  logic [TICK_W-1:0]      edge_sel;
  logic                   lvl_sel;
  logic                   new_lvl;
  logic                   is_edge;
  logic [IN_CH_W-1:0]     cand4;
  logic [IN_CH_W-1:0]     cur4;
  logic                   cand_en;
  logic [CNT_W:0]         div_shl;
  logic [CNT_W:0]         div_dif;
  logic                   div_take;
  logic [AVG_W-1:0]       avg_sat;
  logic                   out_free;
  logic                   in_acc;

  function automatic logic [CH_W-1:0] ch_inc(input logic [CH_W-1:0] c);
    ch_inc = (c == CH_W'(NUM_CHANNELS - 1)) ? '0 : c + 1'b1;
  endfunction

  assign in_ready = (state_r == S_IDLE);
  assign in_acc   = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;

  assign raw5  = CMP_W'({raw_r, 2'b00}) + CMP_W'(raw_r);
  assign hi4   = CMP_W'({th_hi_r, 2'b00});
  assign lo4   = CMP_W'({th_lo_r, 2'b00});
  assign go_hi = raw5 > hi4;
  assign go_lo = raw5 < lo4;
  assign ch_ok = {1'b0, ch_r} < (IN_CH_W + 1)'(NUM_CHANNELS);

  assign sum_sel  = sum_r[idx_r];
  assign cnt_sel  = cnt_r[idx_r];
  assign edge_sel = edge_r[idx_r];
  assign lvl_sel  = lvl_r[idx_r];
  assign new_lvl  = go_hi ? 1'b1 : (go_lo ? 1'b0 : lvl_sel);
  assign is_edge  = go_hi && !lvl_sel;

  assign cand4   = IN_CH_W'(idx_r);
  assign cur4    = IN_CH_W'(cur_r);
  assign cand_en = !cand4[IN_CH_W-1] && en_r[cand4[OUT_CH_W-1:0]];

  assign div_shl  = {rem_r, quo_r[SUM_W-1]};
  assign div_dif  = div_shl - {1'b0, div_r};
  assign div_take = !div_dif[CNT_W];
  assign avg_sat  = (|quo_r[SUM_W-1:AVG_W]) ? '1 : quo_r[AVG_W-1:0];

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = S_EXEC;
      end
      S_EXEC: begin
        unique case (mode_r)
          MODE_TICK:   state_nxt = S_DONE;
          MODE_SAMPLE: state_nxt = (ch_ok && is_edge) ? S_MUL : S_DONE;
          MODE_READ:   state_nxt = (ch_ok && cnt_sel != '0) ? S_DIV : S_DONE;
          MODE_SELECT: state_nxt = S_SEL;
          default:     state_nxt = S_DONE;
        endcase
      end
      S_MUL: begin
        if (step_r == STEP_W'(MUL_STEPS - 1)) state_nxt = S_DONE;
      end
      S_DIV: begin
        if (step_r == STEP_W'(DIV_STEPS - 1)) state_nxt = S_DONE;
      end
      S_SEL: begin
        if (cand_en || step_r == STEP_W'(NUM_CHANNELS - 1)) state_nxt = S_DONE;
      end
      S_DONE: begin
        if (out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      en_r         <= EN_RST;
      th_hi_r      <= TH_HI_RST;
      th_lo_r      <= TH_LO_RST;
      tp_r         <= TP_RST;
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        sum_r[i]  <= '0;
        cnt_r[i]  <= '0;
        edge_r[i] <= '0;
      end
      lvl_r        <= '0;
      tick_r       <= '0;
      cur_r        <= '0;
      out_valid_r  <= 1'b0;
      res_ch_r     <= '0;
      res_edge_r   <= 1'b0;
      res_lvl_r    <= 1'b0;
      res_acc_r    <= 1'b0;
      res_avg_en_r <= 1'b0;
    end else begin
      state_r <= state_nxt;

      if (cfg_we) begin
        unique case (cfg_index)
          CFG_CH_EN:   en_r    <= cfg_data[EN_W-1:0];
          CFG_TH_HI:   th_hi_r <= cfg_data[TH_W-1:0];
          CFG_TH_LO:   th_lo_r <= cfg_data[TH_W-1:0];
          CFG_TICK_US: tp_r    <= cfg_data[TP_W-1:0];
          default: ;
        endcase
      end

      if (state_r == S_EXEC) begin
        res_ch_r     <= (mode_r == MODE_TICK) ? cur4[OUT_CH_W-1:0] : ch_r[OUT_CH_W-1:0];
        res_edge_r   <= ch_ok && (mode_r == MODE_SAMPLE) && is_edge;
        res_lvl_r    <= ch_ok && ((mode_r == MODE_SAMPLE) ? new_lvl
                                                           : (mode_r == MODE_READ) && lvl_sel);
        res_acc_r    <= ch_ok && (mode_r == MODE_SAMPLE || mode_r == MODE_READ);
        res_avg_en_r <= ch_ok && (mode_r == MODE_READ);
        unique case (mode_r)
          MODE_TICK: begin
            tick_r <= tick_r + 1'b1;
          end
          MODE_SAMPLE: begin
            if (ch_ok) begin
              if (cnt_sel != '1) begin
                sum_r[idx_r] <= sum_sel + SUM_W'(raw_r);
                cnt_r[idx_r] <= cnt_sel + 1'b1;
              end
              lvl_r[idx_r] <= new_lvl;
              if (is_edge) edge_r[idx_r] <= tick_r;
            end
          end
          MODE_READ: begin
            if (ch_ok) begin
              sum_r[idx_r] <= '0;
              cnt_r[idx_r] <= '0;
            end
          end
          MODE_SELECT: ;
          default: ;
        endcase
      end

      if (state_r == S_SEL && (cand_en || step_r == STEP_W'(NUM_CHANNELS - 1))) begin
        cur_r     <= idx_r;
        res_ch_r  <= cand4[OUT_CH_W-1:0];
        res_lvl_r <= lvl_sel;
      end

      if (state_r == S_DONE && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      mode_r <= mode_t'(in_mode);
      ch_r   <= in_channel;
      raw_r  <= SAMPLE_BITS'(in_sample_value);
      idx_r  <= (mode_t'(in_mode) == MODE_SELECT) ? ch_inc(cur_r) : in_channel[CH_W-1:0];
    end

    unique case (state_r)
      S_EXEC: begin
        step_r   <= '0;
        mcand_r  <= tick_r - edge_sel;
        mplier_r <= tp_r;
        prod_r   <= '0;
        quo_r    <= (cnt_sel != '0) ? sum_sel : '0;
        rem_r    <= '0;
        div_r    <= cnt_sel;
      end
      S_MUL: begin
        step_r   <= step_r + 1'b1;
        prod_r   <= prod_r + (mplier_r[0] ? mcand_r : '0);
        mcand_r  <= {mcand_r[TICK_W-2:0], 1'b0};
        mplier_r <= {1'b0, mplier_r[TP_W-1:1]};
      end
      S_DIV: begin
        step_r <= step_r + 1'b1;
        rem_r  <= div_take ? div_dif[CNT_W-1:0] : div_shl[CNT_W-1:0];
        quo_r  <= {quo_r[SUM_W-2:0], div_take};
      end
      S_SEL: begin
        step_r <= step_r + 1'b1;
        if (!cand_en) idx_r <= ch_inc(idx_r);
      end
      default: ;
    endcase

    if (state_r == S_DONE && out_free) begin
      out_channel     <= res_ch_r;
      out_average     <= res_avg_en_r ? avg_sat : '0;
      out_period_us   <= res_edge_r ? prod_r : '0;
      out_rising_edge <= res_edge_r;
      out_level       <= res_lvl_r;
      out_accepted    <= res_acc_r;
    end
  end

  `MALPT_ASSERT_IMP(a_edge_sets_level, out_valid_r && out_rising_edge, out_level && out_accepted, "rising edge without high level")
  `MALPT_ASSERT_IMP(a_ignored_zero, out_valid_r && !out_accepted, out_average == '0 && out_period_us == '0 && !out_rising_edge, "ignored request with nonzero result")
  `MALPT_ASSERT_IMP(a_div_nonzero, state_r == S_DIV, div_r != '0, "divide by zero count")
  `MALPT_ASSERT_NXT(a_done_holds, state_r == S_DONE && out_valid_r && !out_ready, state_r == S_DONE, "finished request left while output stalled")

endmodule

@@ verif/testbench.sv @@
`timescale 1ns / 1ps
module testbench;
  import malpt_pkg::*;

  typedef struct packed {
    logic [OUT_CH_W-1:0] chan;
    logic [AVG_W-1:0]    average;
    logic [TICK_W-1:0]   period;
    logic                rising;
    logic                level;
    logic                accepted;
  } tracker_result_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [1:0]           in_mode = MODE_TICK;
  logic [IN_CH_W-1:0]   in_channel = '0;
  logic [RAW_W-1:0]     in_sample_value = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [OUT_CH_W-1:0]  out_channel;
  logic [AVG_W-1:0]     out_average;
  logic [TICK_W-1:0]    out_period_us;
  logic                 out_rising_edge;
  logic                 out_level;
  logic                 out_accepted;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_CH_EN;
  logic [CFG_W-1:0]     cfg_data = '0;

  // predictor state
  logic [EN_W-1:0]   en_mask;
  logic [TH_W-1:0]   th_hi;
  logic [TH_W-1:0]   th_lo;
  logic [TP_W-1:0]   tick_us;
  logic [SUM_W-1:0]  acc_sum [NUM_CHANNELS];
  logic [CNT_W-1:0]  acc_count [NUM_CHANNELS];
  logic              lvl_q [NUM_CHANNELS];
  logic [TICK_W-1:0] last_edge_tick [NUM_CHANNELS];
  logic [TICK_W-1:0] tick_count;
  logic [CH_W-1:0]   sel_channel;

  tracker_result_t pending_results [$];
  tracker_result_t head_result;
  int error_count = 0;
  int sent_count = 0;
  int checked_count = 0;
  int sender_idle_pct = 0;
  int receiver_stall_pct = 0;

  multichannel_adc_level_period_tracker u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_mode         (in_mode),
    .in_channel      (in_channel),
    .in_sample_value (in_sample_value),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_channel     (out_channel),
    .out_average     (out_average),
    .out_period_us   (out_period_us),
    .out_rising_edge (out_rising_edge),
    .out_level       (out_level),
    .out_accepted    (out_accepted),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  always #2 clk = ~clk;

  function automatic void reset_tracker_model();
    en_mask = EN_RST;
    th_hi = TH_HI_RST;
    th_lo = TH_LO_RST;
    tick_us = TP_RST;
    for (int i = 0; i < NUM_CHANNELS; i++) begin
      acc_sum[i] = '0;
      acc_count[i] = '0;
      lvl_q[i] = 1'b0;
      last_edge_tick[i] = '0;
    end
    tick_count = '0;
    sel_channel = '0;
  endfunction

  function automatic tracker_result_t compute_tracker_result(
    mode_t m, logic [IN_CH_W-1:0] ch, logic [RAW_W-1:0] raw);
    tracker_result_t r;
    logic [CH_W-1:0] c;
    logic [CH_W-1:0] idx;
    logic [SUM_W-1:0] avg;
    int unsigned scaled;
    int unsigned hi_lim;
    int unsigned lo_lim;
    bit found;
    r = '0;
    c = ch[CH_W-1:0];
    scaled = int'(raw) * 5;
    hi_lim = int'(th_hi) * 4;
    lo_lim = int'(th_lo) * 4;
    case (m)
      MODE_TICK: begin
        tick_count = tick_count + 1;
        r.chan = sel_channel;
      end
      MODE_SAMPLE: begin
        r.chan = c;
        if (ch < NUM_CHANNELS) begin
          if (acc_count[c] != {CNT_W{1'b1}}) begin
            acc_sum[c] = acc_sum[c] + {{(SUM_W-RAW_W){1'b0}}, raw};
            acc_count[c] = acc_count[c] + 1;
          end
          if (scaled > hi_lim) begin
            if (!lvl_q[c]) begin
              r.period = (tick_count - last_edge_tick[c]) * {16'd0, tick_us};
              r.rising = 1'b1;
              last_edge_tick[c] = tick_count;
            end
            lvl_q[c] = 1'b1;
          end else if (scaled < lo_lim) begin
            lvl_q[c] = 1'b0;
          end
          r.level = lvl_q[c];
          r.accepted = 1'b1;
        end
      end
      MODE_READ: begin
        r.chan = c;
        if (ch < NUM_CHANNELS) begin
          avg = '0;
          if (acc_count[c] != 0) avg = acc_sum[c] / {16'd0, acc_count[c]};
          if (avg > 4095) avg = 4095;
          r.average = avg[AVG_W-1:0];
          acc_sum[c] = '0;
          acc_count[c] = '0;
          r.level = lvl_q[c];
          r.accepted = 1'b1;
        end
      end
      default: begin
        found = 1'b0;
        for (int i = 1; i <= NUM_CHANNELS; i++) begin
          idx = CH_W'(sel_channel + i);
          if (!found && en_mask[idx]) begin
            sel_channel = idx;
            found = 1'b1;
          end
        end
        r.chan = sel_channel;
        r.level = lvl_q[sel_channel];
      end
    endcase
    return r;
  endfunction

  task automatic send_request(input mode_t m, input logic [IN_CH_W-1:0] ch,
                              input logic [RAW_W-1:0] raw);
    int gap;
    gap = 0;
    while (gap < 60 && $urandom_range(0, 99) < sender_idle_pct) gap++;
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_mode <= m;
    in_channel <= ch;
    in_sample_value <= raw;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_results.push_back(compute_tracker_result(m, ch, raw));
    sent_count++;
  endtask

  task automatic wait_idle(input int drain);
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (drain) @(posedge clk);
  endtask

  task automatic write_register(input cfg_idx_t idx, input logic [CFG_W-1:0] data);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_CH_EN:   en_mask = data[EN_W-1:0];
      CFG_TH_HI:   th_hi = data;
      CFG_TH_LO:   th_lo = data;
      CFG_TICK_US: tick_us = data;
      default: ;
    endcase
  endtask

  task automatic set_tracker_config(input logic [EN_W-1:0] en, input logic [TH_W-1:0] hi,
                                    input logic [TH_W-1:0] lo, input logic [TP_W-1:0] tp);
    wait_idle(4);
    write_register(CFG_CH_EN, {8'd0, en});
    write_register(CFG_TH_HI, hi);
    write_register(CFG_TH_LO, lo);
    write_register(CFG_TICK_US, tp);
  endtask

  task automatic check_field(input string name, input logic [31:0] expv,
                             input logic [31:0] actv);
    if (expv !== actv) begin
      $error("%s: expected %0d, got %0d", name, expv, actv);
      error_count++;
    end
  endtask

  always @(negedge clk) out_ready <= ($urandom_range(0, 99) >= receiver_stall_pct);

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result: channel %0d", out_channel);
        error_count++;
      end else begin
        head_result = pending_results.pop_front();
        check_field("out_channel", head_result.chan, out_channel);
        check_field("out_average", head_result.average, out_average);
        check_field("out_period_us", head_result.period, out_period_us);
        check_field("out_rising_edge", head_result.rising, out_rising_edge);
        check_field("out_level", head_result.level, out_level);
        check_field("out_accepted", head_result.accepted, out_accepted);
        checked_count++;
      end
    end
  end

  task automatic test_reset_defaults();
    send_request(MODE_READ, 4'd0, 12'd0);
    send_request(MODE_TICK, 4'd9, 12'd4095);
    send_request(MODE_TICK, 4'd0, 12'd0);
    send_request(MODE_SAMPLE, 4'd0, 12'd4095);
    send_request(MODE_SAMPLE, 4'd0, 12'd0);
    send_request(MODE_SAMPLE, 4'd7, 12'd2001);
    send_request(MODE_SAMPLE, 4'd7, 12'd2000);
    send_request(MODE_READ, 4'd0, 12'd0);
    send_request(MODE_SELECT, 4'd15, 12'd0);
  endtask

  task automatic test_invalid_channels();
    send_request(MODE_SAMPLE, 4'd8, 12'd4095);
    send_request(MODE_SAMPLE, 4'd15, 12'd4095);
    send_request(MODE_READ, 4'd12, 12'd0);
    send_request(MODE_READ, 4'd15, 12'd0);
  endtask

  task automatic test_threshold_overlap();
    set_tracker_config(8'hFF, 16'd100, 16'd4000, TP_RST);
    send_request(MODE_SAMPLE, 4'd2, 12'd1000);
    send_request(MODE_SAMPLE, 4'd2, 12'd81);
    set_tracker_config(8'hFF, 16'd0, 16'hFFFF, TP_RST);
    send_request(MODE_SAMPLE, 4'd2, 12'd0);
    send_request(MODE_SAMPLE, 4'd2, 12'd1);
  endtask

  task automatic test_channel_select();
    set_tracker_config(8'h00, TH_HI_RST, TH_LO_RST, TP_RST);
    send_request(MODE_SELECT, 4'd0, 12'd0);
    set_tracker_config(8'h80, TH_HI_RST, TH_LO_RST, TP_RST);
    send_request(MODE_SELECT, 4'd0, 12'd0);
    send_request(MODE_SELECT, 4'd0, 12'd0);
    set_tracker_config(8'h05, TH_HI_RST, TH_LO_RST, TP_RST);
    send_request(MODE_SELECT, 4'd0, 12'd0);
    send_request(MODE_SELECT, 4'd0, 12'd0);
  endtask

  task automatic test_zero_tick_period();
    set_tracker_config(8'hFF, TH_HI_RST, TH_LO_RST, 16'd0);
    send_request(MODE_SAMPLE, 4'd4, 12'd0);
    send_request(MODE_TICK, 4'd0, 12'd0);
    send_request(MODE_SAMPLE, 4'd4, 12'd4095);
  endtask

  task automatic run_random_phase(input int n);
    int r;
    int t;
    mode_t m;
    logic [IN_CH_W-1:0] ch;
    for (int k = 0; k < n; k++) begin
      r = $urandom_range(0, 99);
      if (r < 30) m = MODE_TICK;
      else if (r < 75) m = MODE_SAMPLE;
      else if (r < 87) m = MODE_READ;
      else m = MODE_SELECT;
      if ((m == MODE_SAMPLE || m == MODE_READ) && $urandom_range(0, 99) < 88)
        ch = IN_CH_W'($urandom_range(0, NUM_CHANNELS - 1));
      else
        ch = IN_CH_W'($urandom_range(0, 15));
      r = $urandom_range(0, 99);
      if (r < 20) t = int'(th_hi) * 4 / 5 + $urandom_range(0, 6) - 3;
      else if (r < 40) t = int'(th_lo) * 4 / 5 + $urandom_range(0, 6) - 3;
      else if (r < 50) t = 0;
      else if (r < 60) t = 4095;
      else t = $urandom_range(0, 4095);
      if (t < 0) t = 0;
      if (t > 4095) t = 4095;
      send_request(m, ch, RAW_W'(t));
    end
  endtask

  task automatic test_random_traffic();
    sender_idle_pct = 0;
    receiver_stall_pct = 0;
    set_tracker_config(EN_W'($urandom), TH_W'($urandom_range(0, 5200)),
                       TH_W'($urandom_range(0, 5200)), 16'hFFFF);
    run_random_phase(370);
    sender_idle_pct = 86;
    set_tracker_config(EN_W'(1 << $urandom_range(0, 7)), 16'd0, 16'hFFFF, 16'd1);
    run_random_phase(370);
    sender_idle_pct = 0;
    receiver_stall_pct = 86;
    set_tracker_config(8'h00, 16'hFFFF, TH_W'($urandom_range(0, 5200)),
                       TP_W'($urandom_range(1, 65535)));
    run_random_phase(370);
    sender_idle_pct = 25;
    receiver_stall_pct = 25;
    set_tracker_config(EN_W'($urandom), TH_W'($urandom_range(1500, 5200)),
                       TH_W'($urandom_range(0, 2000)), TP_W'($urandom_range(1, 65535)));
    run_random_phase(370);
  endtask

  task automatic test_long_period();
    sender_idle_pct = 0;
    receiver_stall_pct = 0;
    set_tracker_config(8'hFF, TH_HI_RST, TH_LO_RST, 16'hFFFF);
    send_request(MODE_SAMPLE, 4'd6, 12'd0);
    repeat (30) send_request(MODE_TICK, 4'd0, 12'd0);
    send_request(MODE_SAMPLE, 4'd6, 12'd4095);
    send_request(MODE_READ, 4'd6, 12'd0);
  endtask

  initial begin
    reset_tracker_model();
    repeat (4) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;
    sender_idle_pct = 25;
    receiver_stall_pct = 25;
    test_reset_defaults();
    test_invalid_channels();
    test_threshold_overlap();
    test_channel_select();
    test_zero_tick_period();
    test_random_traffic();
    test_long_period();
    wait_idle(60);
    $display("Sent %0d requests, checked %0d results: ticks, samples, reads, selects,",
             sent_count, checked_count);
    $display("bad channels, overlapping thresholds, zero and long tick periods.");
    if (error_count == 0) begin
      $display("** multichannel_adc_level_period_tracker: PASSED **");
    end else begin
      $display("** multichannel_adc_level_period_tracker: FAILED **");
    end
    $finish;
  end

  initial begin
    #40_000_000;
    $display("timeout with %0d results outstanding", pending_results.size());
    $display("** multichannel_adc_level_period_tracker: FAILED **");
    $finish;
  end

endmodule
